// ===== rtl/rtgp_pkg.sv =====
// rtgp_pkg: shared constants, types and the sign-magnitude decode for the
// radar target frame parser; no dependencies
`default_nettype none

package rtgp_pkg;

	// default number of targets in one frame, and bytes per target
	localparam int TARGET_COUNT_DEF = 3;
	localparam int TGT_BYTES        = 8;
	localparam int SLOT_W           = 3;

	// header and tail bytes
	localparam logic [7:0] HDR_0  = 8'hAA;
	localparam logic [7:0] HDR_1  = 8'hFF;
	localparam logic [7:0] HDR_2  = 8'h03;
	localparam logic [7:0] HDR_3  = 8'h00;
	localparam logic [7:0] TAIL_0 = 8'h55;
	localparam logic [7:0] TAIL_1 = 8'hCC;

	// sign-magnitude word layout
	localparam logic [15:0] SIGN_MASK = 16'h8000;
	localparam logic [15:0] MAG_MASK  = 16'h7FFF;

	// hunt phases
	typedef enum logic [4:0] {
		PH_WAIT_AA = 5'b00001,
		PH_WAIT_FF = 5'b00010,
		PH_WAIT_03 = 5'b00100,
		PH_WAIT_00 = 5'b01000,
		PH_BODY    = 5'b10000
	} phase_t;

	// one finished target, raw words
	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] slot;
		logic              present;
		logic [15:0]       wx;
		logic [15:0]       wy;
		logic [15:0]       ws;
	} tgt_wr_t;

	// what the byte now offered at the input would finish
	typedef struct packed {
		logic              tgt_end;
		logic              frame_end;
		logic [SLOT_W-1:0] slot;
	} hunt_stat_t;

	// drain progress of the result side
	typedef struct packed {
		logic              active;
		logic [SLOT_W-1:0] idx;
	} drain_stat_t;

	// bit 15 set: positive magnitude, else negated; minus zero gives zero
	function automatic logic signed [15:0] sm_decode(input logic [15:0] w);
		logic [15:0] mag;
		mag = w & MAG_MASK;
		if ((w & SIGN_MASK) != 16'h0000)
			sm_decode = signed'(mag);
		else
			sm_decode = signed'(16'h0000 - mag);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rtgp_hunt.sv =====
// rtgp_hunt: header hunt, body byte counter, target word assembly, tail check
// depends on rtgp_pkg
`default_nettype none

module rtgp_hunt #(
	parameter int TARGET_COUNT = rtgp_pkg::TARGET_COUNT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_fire,
	input  wire logic [7:0]           rx_byte,
	output rtgp_pkg::hunt_stat_t      stat,
	output rtgp_pkg::tgt_wr_t         wr_s1,
	output logic                      done_s1
);
	import rtgp_pkg::*;

	localparam int TGT_END  = TGT_BYTES * TARGET_COUNT;
	localparam int BODY_LEN = TGT_END + 2;
	localparam int CNT_W    = $clog2(BODY_LEN);

	phase_t           phase_q;
	logic [CNT_W-1:0] byte_count_q;
	logic [7:0]       tbyte_q [7];
	logic             tail55_q;
	logic [2:0]       pos;
	logic             in_body;
	logic [15:0]      wd;

	// decode of the current position in the body
	assign in_body        = (phase_q == PH_BODY);
	assign pos            = byte_count_q[2:0];
	assign stat.tgt_end   = in_body && (byte_count_q < CNT_W'(TGT_END)) && (pos == 3'd7);
	assign stat.frame_end = in_body && (byte_count_q == CNT_W'(BODY_LEN - 1));
	assign stat.slot      = SLOT_W'(byte_count_q >> 3);
	assign wd             = {rx_byte, tbyte_q[6]};

	// header hunt and body counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_WAIT_AA;
			byte_count_q <= '0;
		end else if (in_fire) begin
			case (phase_q)
				PH_WAIT_FF: phase_q <= (rx_byte == HDR_1) ? PH_WAIT_03 : PH_WAIT_AA;
				PH_WAIT_03: phase_q <= (rx_byte == HDR_2) ? PH_WAIT_00 : PH_WAIT_AA;
				PH_WAIT_00: begin
					byte_count_q <= '0;
					phase_q      <= (rx_byte == HDR_3) ? PH_BODY : PH_WAIT_AA;
				end
				PH_BODY: begin
					if (stat.frame_end) begin
						byte_count_q <= '0;
						phase_q      <= PH_WAIT_AA;
					end else begin
						byte_count_q <= byte_count_q + CNT_W'(1);
					end
				end
				default: phase_q <= (rx_byte == HDR_0) ? PH_WAIT_FF : PH_WAIT_AA;
			endcase
		end
	end

	// target bytes and first tail byte
	always_ff @(posedge clk) begin
		if (in_fire && in_body) begin
			if (pos != 3'd7)
				tbyte_q[pos] <= rx_byte;
			if (byte_count_q == CNT_W'(TGT_END))
				tail55_q <= (rx_byte == TAIL_0);
		end
	end

	// finished target and frame, registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1   <= '0;
			done_s1 <= 1'b0;
		end else begin
			wr_s1.we   <= in_fire && stat.tgt_end;
			wr_s1.slot <= stat.slot;
			wr_s1.wx   <= {tbyte_q[1], tbyte_q[0]};
			wr_s1.wy   <= {tbyte_q[3], tbyte_q[2]};
			wr_s1.ws   <= {tbyte_q[5], tbyte_q[4]};
			wr_s1.present <= (tbyte_q[0] != 8'h00) || (tbyte_q[1] != 8'h00) ||
				(tbyte_q[2] != 8'h00) || (tbyte_q[3] != 8'h00) ||
				(tbyte_q[4] != 8'h00) || (tbyte_q[5] != 8'h00) || (wd != 16'h0000);
			done_s1 <= in_fire && stat.frame_end && tail55_q && (rx_byte == TAIL_1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rtgp_slot_buf.sv =====
// rtgp_slot_buf: per-target word buffer, drain sequencing and result register
// depends on rtgp_pkg
`default_nettype none

module rtgp_slot_buf #(
	parameter int TARGET_COUNT = rtgp_pkg::TARGET_COUNT_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  rtgp_pkg::tgt_wr_t           wr_s1,
	input  wire logic                   done_s1,
	output rtgp_pkg::drain_stat_t       drain,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [2:0]                  target_slot,
	output logic                        present,
	output logic signed [15:0]          pos_x_mm,
	output logic signed [15:0]          pos_y_mm,
	output logic signed [15:0]          speed_mm_s,
	output logic                        last_target
);
	import rtgp_pkg::*;

	localparam int IDX_W = (TARGET_COUNT > 1) ? $clog2(TARGET_COUNT) : 1;

	logic [15:0]      x_buf [TARGET_COUNT];
	logic [15:0]      y_buf [TARGET_COUNT];
	logic [15:0]      s_buf [TARGET_COUNT];
	logic             p_buf [TARGET_COUNT];
	logic             active_q;
	logic [IDX_W-1:0] idx_q;
	logic             load;
	logic             is_last;

	assign load         = active_q && (!out_valid || out_ready);
	assign is_last      = (idx_q == IDX_W'(TARGET_COUNT - 1));
	assign drain.active = active_q;
	assign drain.idx    = SLOT_W'(idx_q);

	// target buffer write
	always_ff @(posedge clk) begin
		if (wr_s1.we) begin
			x_buf[wr_s1.slot[IDX_W-1:0]] <= wr_s1.wx;
			y_buf[wr_s1.slot[IDX_W-1:0]] <= wr_s1.wy;
			s_buf[wr_s1.slot[IDX_W-1:0]] <= wr_s1.ws;
			p_buf[wr_s1.slot[IDX_W-1:0]] <= wr_s1.present;
		end
	end

	// drain sequencing and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (done_s1) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (load) begin
				if (is_last)
					active_q <= 1'b0;
				else
					idx_q <= idx_q + IDX_W'(1);
			end
			if (load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			target_slot <= 3'(idx_q);
			present     <= p_buf[idx_q];
			pos_x_mm    <= sm_decode(x_buf[idx_q]);
			pos_y_mm    <= sm_decode(y_buf[idx_q]);
			speed_mm_s  <= sm_decode(s_buf[idx_q]);
			last_target <= is_last;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/radar_target_frame_parser.sv =====
// radar_target_frame_parser: top level, byte stream in, decoded targets out
// depends on rtgp_pkg, rtgp_hunt, rtgp_slot_buf
//
//   channel   handshake              payload
//   input     in_valid / in_ready    rx_byte
//   output    out_valid / out_ready  target_slot present pos_x_mm pos_y_mm
//                                    speed_mm_s last_target
//
// one byte per cycle while in_ready is high; a good tail gives TARGET_COUNT results,
// one per cycle unless out_ready stalls them, read from the target buffer
// arst_n clears the hunt phase, byte counter and drain state; buffers hold junk
// in_ready drops only for a byte that would overwrite a target not yet moved
// into the result register, or close a frame while the last one still drains
`default_nettype none

module radar_target_frame_parser #(
	parameter int TARGET_COUNT = rtgp_pkg::TARGET_COUNT_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    rx_byte,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [2:0]         target_slot,
	output logic               present,
	output logic signed [15:0] pos_x_mm,
	output logic signed [15:0] pos_y_mm,
	output logic signed [15:0] speed_mm_s,
	output logic               last_target
);
	import rtgp_pkg::*;

	hunt_stat_t  hstat;
	drain_stat_t dstat;
	tgt_wr_t     wr_s1;
	logic        done_s1;
	logic        in_fire;

	// input backpressure against undrained targets
	assign in_ready = !(dstat.active && hstat.tgt_end && (hstat.slot >= dstat.idx)) &&
		!(dstat.active && hstat.frame_end);
	assign in_fire  = in_valid && in_ready;

	rtgp_hunt #(.TARGET_COUNT(TARGET_COUNT)) u_hunt (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.rx_byte (rx_byte),
		.stat    (hstat),
		.wr_s1   (wr_s1),
		.done_s1 (done_s1)
	);

	rtgp_slot_buf #(.TARGET_COUNT(TARGET_COUNT)) u_slot_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_s1       (wr_s1),
		.done_s1     (done_s1),
		.drain       (dstat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.target_slot (target_slot),
		.present     (present),
		.pos_x_mm    (pos_x_mm),
		.pos_y_mm    (pos_y_mm),
		.speed_mm_s  (speed_mm_s),
		.last_target (last_target)
	);

endmodule

`default_nettype wire

// ===== rtl/rtgp_checker.sv =====
// rtgp_checker: port-level assertions for the radar target frame parser,
// bound to the top level; depends on rtgp_pkg
`default_nettype none

module rtgp_checker #(
	parameter int TARGET_COUNT = rtgp_pkg::TARGET_COUNT_DEF
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [2:0]         target_slot,
	input wire logic               present,
	input wire logic signed [15:0] pos_x_mm,
	input wire logic signed [15:0] pos_y_mm,
	input wire logic signed [15:0] speed_mm_s,
	input wire logic               last_target
);
	import rtgp_pkg::*;

	// a stalled result beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(target_slot) &&
		$stable(pos_x_mm) && $stable(pos_y_mm) && $stable(speed_mm_s) &&
		$stable(present) && $stable(last_target))
		else $error("result beat changed while stalled");

	// targets of a frame follow each other with no gap
	a_slot_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_target |=>
		out_valid && (target_slot == $past(target_slot) + 3'd1))
		else $error("target slots not consecutive");

	// the last target carries the top slot index
	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_target |-> (target_slot == 3'(TARGET_COUNT - 1)))
		else $error("last target on wrong slot");

	// an absent target decodes to all zero
	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !present |-> (pos_x_mm == 16'sd0) && (pos_y_mm == 16'sd0) &&
		(speed_mm_s == 16'sd0))
		else $error("absent target with nonzero values");

endmodule

bind radar_target_frame_parser rtgp_checker #(.TARGET_COUNT(TARGET_COUNT)) u_rtgp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.target_slot (target_slot),
	.present     (present),
	.pos_x_mm    (pos_x_mm),
	.pos_y_mm    (pos_y_mm),
	.speed_mm_s  (speed_mm_s),
	.last_target (last_target)
);

`default_nettype wire

// ===== tb/sv/radar_target_frame_checker.sv =====
`timescale 1ns / 1ps
// radar_target_frame_checker: watches both channels of the frame parser,
// predicts the decoded targets and compares every output beat
// depends on rtgp_pkg
`default_nettype none

module radar_target_frame_checker #(
	parameter int TARGET_COUNT = rtgp_pkg::TARGET_COUNT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic [2:0]         target_slot,
	input  wire logic               present,
	input  wire logic signed [15:0] pos_x_mm,
	input  wire logic signed [15:0] pos_y_mm,
	input  wire logic signed [15:0] speed_mm_s,
	input  wire logic               last_target,
	output int                      mismatch_count,
	output int                      pending
);
	import rtgp_pkg::*;

	localparam int FRAME_LEN = TGT_BYTES * TARGET_COUNT + 2;

	typedef struct packed {
		logic [2:0]         slot;
		logic               present;
		logic signed [15:0] x_mm;
		logic signed [15:0] y_mm;
		logic signed [15:0] speed;
		logic               last;
	} target_rec_t;

	// predicted targets, oldest first
	target_rec_t target_q[$];

	// predictor state
	phase_t     hunt;
	int         body_cnt;
	logic [7:0] body[FRAME_LEN];

	// bit 15 set means positive; minus zero comes out as zero
	function automatic logic signed [15:0] sm_to_mm(input logic [15:0] w);
		logic signed [15:0] mag;
		mag = signed'({1'b0, w[14:0]});
		return w[15] ? mag : -mag;
	endfunction

	// decode a complete frame into one record per target
	task automatic decode_frame();
		int          base;
		logic [15:0] wx, wy, ws, wd;
		target_rec_t rec;
		for (int t = 0; t < TARGET_COUNT; t++) begin
			base = t * TGT_BYTES;
			wx = {body[base + 1], body[base]};
			wy = {body[base + 3], body[base + 2]};
			ws = {body[base + 5], body[base + 4]};
			wd = {body[base + 7], body[base + 6]};
			rec.slot    = t[2:0];
			rec.present = |{wx, wy, ws, wd};
			rec.x_mm    = sm_to_mm(wx);
			rec.y_mm    = sm_to_mm(wy);
			rec.speed   = sm_to_mm(ws);
			rec.last    = (t == TARGET_COUNT - 1);
			target_q.push_back(rec);
		end
	endtask

	// header hunt; a mismatching byte is not retried as a first header byte
	task automatic take_rx_byte(input logic [7:0] b);
		case (hunt)
			PH_WAIT_FF: hunt = (b == HDR_1) ? PH_WAIT_03 : PH_WAIT_AA;
			PH_WAIT_03: hunt = (b == HDR_2) ? PH_WAIT_00 : PH_WAIT_AA;
			PH_WAIT_00: begin
				if (b == HDR_3) begin
					body_cnt = 0;
					hunt = PH_BODY;
				end else begin
					hunt = PH_WAIT_AA;
				end
			end
			PH_BODY: begin
				body[body_cnt] = b;
				body_cnt++;
				if (body_cnt >= FRAME_LEN) begin
					if (body[FRAME_LEN - 2] == TAIL_0 && body[FRAME_LEN - 1] == TAIL_1)
						decode_frame();
					hunt = PH_WAIT_AA;
					body_cnt = 0;
				end
			end
			default: hunt = (b == HDR_0) ? PH_WAIT_FF : PH_WAIT_AA;
		endcase
	endtask

	task automatic flag_error(input string what, input target_rec_t want,
	                          input target_rec_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display({"%0t %s: expected slot=%0d present=%0b x=%0d y=%0d speed=%0d",
				" last=%0b, got slot=%0d present=%0b x=%0d y=%0d speed=%0d last=%0b"},
				$realtime, what, want.slot, want.present, want.x_mm, want.y_mm,
				want.speed, want.last, got.slot, got.present, got.x_mm, got.y_mm,
				got.speed, got.last);
	endtask

	// compare output beats first, then predict from the input beat
	always @(posedge clk or negedge arst_n) begin
		target_rec_t got;
		target_rec_t want;
		if (!arst_n) begin
			target_q.delete();
			hunt = PH_WAIT_AA;
			body_cnt = 0;
			mismatch_count = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {target_slot, present, pos_x_mm, pos_y_mm, speed_mm_s, last_target};
				if (target_q.size() == 0) begin
					want = '0;
					flag_error("unexpected target", want, got);
				end else begin
					want = target_q.pop_front();
					if (got.slot !== want.slot || got.present !== want.present ||
					    got.x_mm !== want.x_mm || got.y_mm !== want.y_mm ||
					    got.speed !== want.speed || got.last !== want.last)
						flag_error("target mismatch", want, got);
				end
			end
			if (in_valid && in_ready)
				take_rx_byte(rx_byte);
			pending = target_q.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/radar_target_frame_parser_tb.sv =====
`timescale 1ns / 1ps
// radar_target_frame_parser_tb: byte stream stimulus, output stalls and verdict
// depends on rtgp_pkg, radar_target_frame_parser, radar_target_frame_checker
`default_nettype none

module radar_target_frame_parser_tb;
	import rtgp_pkg::*;

	localparam int TGT_N        = TARGET_COUNT_DEF;
	localparam int RX_ITEMS     = 320;
	localparam int PHASE_BYTES  = 48;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 400000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         target_slot;
	logic               present;
	logic signed [15:0] pos_x_mm;
	logic signed [15:0] pos_y_mm;
	logic signed [15:0] speed_mm_s;
	logic               last_target;

	int tx_idle_pct;
	int rx_stall_pct;
	int bytes_sent;
	int cycles = 0;
	int mismatch_count;
	int pending;

	radar_target_frame_parser #(.TARGET_COUNT(TGT_N)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.target_slot(target_slot), .present(present),
		.pos_x_mm(pos_x_mm), .pos_y_mm(pos_y_mm), .speed_mm_s(speed_mm_s),
		.last_target(last_target)
	);

	radar_target_frame_checker #(.TARGET_COUNT(TGT_N)) chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.target_slot(target_slot), .present(present),
		.pos_x_mm(pos_x_mm), .pos_y_mm(pos_y_mm), .speed_mm_s(speed_mm_s),
		.last_target(last_target),
		.mismatch_count(mismatch_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver stalls at the current rate
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= rx_stall_pct);

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// one input beat, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_word(input logic [15:0] w);
		send_byte(w[7:0]);
		send_byte(w[15:8]);
	endtask

	task automatic send_header();
		send_byte(HDR_0);
		send_byte(HDR_1);
		send_byte(HDR_2);
		send_byte(HDR_3);
	endtask

	task automatic send_target(input logic [15:0] wx, input logic [15:0] wy,
	                           input logic [15:0] ws, input logic [15:0] wd);
		send_word(wx);
		send_word(wy);
		send_word(ws);
		send_word(wd);
	endtask

	function automatic logic [7:0] byte_other_than(input logic [7:0] v);
		logic [7:0] r;
		do r = 8'($urandom_range(255)); while (r == v);
		return r;
	endfunction

	// word biased toward the sign-magnitude corners
	function automatic logic [15:0] pick_word();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'h8000;
			2: return 16'h7FFF;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_tail(input bit good);
		logic [7:0] t0, t1;
		t0 = TAIL_0;
		t1 = TAIL_1;
		if (!good) begin
			case ($urandom_range(2))
				0: t0 = byte_other_than(TAIL_0);
				1: t1 = byte_other_than(TAIL_1);
				default: begin
					t0 = TAIL_1;
					t1 = TAIL_0;
				end
			endcase
		end
		send_byte(t0);
		send_byte(t1);
	endtask

	// frame with random targets; the tail is good or bad as asked
	task automatic send_random_frame(input bit good);
		int sel;
		send_header();
		for (int t = 0; t < TGT_N; t++) begin
			sel = $urandom_range(99);
			if (sel < 15)
				send_target(16'h0000, 16'h0000, 16'h0000, 16'h0000);
			else if (sel < 25)
				send_target(16'h0000, 16'h0000, 16'h0000, pick_word() | 16'h0001);
			else
				send_target(pick_word(), pick_word(), pick_word(), pick_word());
		end
		send_tail(good);
	endtask

	// header cut short by a wrong byte
	task automatic send_broken_header();
		logic [7:0] hdr[4];
		int         keep;
		hdr = '{HDR_0, HDR_1, HDR_2, HDR_3};
		keep = $urandom_range(1, 3);
		for (int i = 0; i < keep; i++)
			send_byte(hdr[i]);
		send_byte(($urandom_range(3) == 0) ? HDR_0 : byte_other_than(hdr[keep]));
	endtask

	// idle rates step through the phases as the random part goes on
	task automatic set_idle_phase(input int done);
		case (done / PHASE_BYTES)
			1: begin
				tx_idle_pct  = 79;
				rx_stall_pct = 0;
			end
			2: begin
				tx_idle_pct  = 0;
				rx_stall_pct = 79;
			end
			3: begin
				tx_idle_pct  = 28;
				rx_stall_pct = 28;
			end
			default: begin
				tx_idle_pct  = 0;
				rx_stall_pct = 0;
			end
		endcase
	endtask

	initial begin
		int sel;
		int n;
		int dir_bytes;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		rx_byte      = 8'h00;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		bytes_sent   = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners: absent target, plus and minus zero, full-scale magnitudes
		send_header();
		send_target(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_target(16'h8000, 16'h0000, 16'hFFFF, 16'h0000);
		send_target(16'h7FFF, 16'h0001, 16'h8001, 16'h0000);
		for (int t = 3; t < TGT_N; t++)
			send_target(16'h5A5A, 16'hA5A5, 16'h8000, 16'hFFFF);
		send_tail(1'b1);

		// repeated first header byte is not a resync; wrong last header byte
		send_byte(HDR_0);
		send_byte(HDR_0);
		send_byte(HDR_1);
		send_byte(HDR_0);
		send_byte(HDR_1);
		send_byte(HDR_2);
		send_byte(8'h01);

		// only the pixel distance nonzero still counts as present
		send_header();
		send_target(16'h0000, 16'h0000, 16'h0000, 16'h1234);
		for (int t = 1; t < TGT_N; t++)
			send_target(16'h0000, 16'h0000, 16'h0000, 16'h8000);
		send_tail(1'b1);

		// bad tail, then a frame right behind it
		send_random_frame(1'b0);
		send_random_frame(1'b1);

		// hold off until the output side is empty
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);

		// random frames, broken headers and noise
		dir_bytes = bytes_sent;
		while (bytes_sent < RX_ITEMS) begin
			set_idle_phase(bytes_sent - dir_bytes);
			sel = $urandom_range(99);
			if (sel < 70) begin
				send_random_frame($urandom_range(99) < 85);
			end else if (sel < 85) begin
				send_broken_header();
			end else begin
				n = $urandom_range(1, 8);
				repeat (n)
					send_byte(8'($urandom_range(255)));
			end
		end

		// let the last results drain
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/rtgp_pkg.sv
rtl/rtgp_hunt.sv
rtl/rtgp_slot_buf.sv
rtl/radar_target_frame_parser.sv
rtl/rtgp_checker.sv
tb/sv/radar_target_frame_checker.sv
tb/sv/radar_target_frame_parser_tb.sv
